### hw/rtl/aes_pkg.sv
package aes_pkg;

  localparam logic [1:0] KL_128 = 2'd0;
  localparam logic [1:0] KL_192 = 2'd1;
  localparam logic [1:0] KL_256 = 2'd2;
  localparam logic [1:0] KL_INV = 2'd3;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // control from sequencer to round unit
  typedef struct packed {
    logic load;   // take plaintext, add round key 0
    logic step;   // perform one round
    logic last;   // final round, no mixcolumns
  } aes_rnd_ctl_t;

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

### hw/rtl/aes_block_encrypt.sv
// AES-128/192/256 encryption core. Each input beat carries one 128-bit block
// and produces one output beat. After the beat is taken the core first runs
// the key expansion, one key word per cycle (4*(Nr+1) words: 44, 52 or 60)
// into a round key store, then the initial add-key, Nr rounds of one round
// unit at one round per cycle, and a result register that drives out_tvalid.
// in_tready is low while a block is in work and while its result waits; it
// rises the cycle after the output beat is taken. Key length code 3 skips the
// key expansion and rounds and gives status 1 and a zero ciphertext through
// the output state. Key registers sit at byte addresses 8*i over a 64-bit
// APB port.
module aes_block_encrypt import aes_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,    // block_high, block_low
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,   // cipher_high, cipher_low, status, zero fill
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [5:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_KEXP = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_RND  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  localparam logic [2:0] REG_KL = 3'd0;
  localparam logic [2:0] REG_K0 = 3'd1;
  localparam logic [2:0] REG_K1 = 3'd2;
  localparam logic [2:0] REG_K2 = 3'd3;
  localparam logic [2:0] REG_K3 = 3'd4;

  logic [1:0]   key_len_r;
  logic [63:0]  key_r [4];
  logic [2:0]   st_r, st_nxt;
  logic [5:0]   widx_r, widx_nxt;
  logic [3:0]   rnd_r, rnd_nxt;
  logic [127:0] blk_r;
  logic [127:0] res_r;
  logic         stat_r;
  logic         ovld_r;
  logic [3:0][31:0] rk_mem [16];    // one round key per entry, word 0 on top
  logic [31:0]  w1_r;               // previous word
  logic [31:0]  wnk [8];            // last nk words, shift line
  logic [2:0]   kmod_r;             // i mod nk
  logic [7:0]   rcon_r;
  logic [127:0] rkey_r;
  logic [5:0]   nwords;
  logic [3:0]   nr;
  logic [2:0]   nk_m1;
  logic [31:0]  kw_new, t;
  logic [127:0] rstate;
  aes_rnd_ctl_t ctl;
  logic         cfg_wr;
  logic         in_acc;
  logic [2:0]   ra;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign ra = cfg_paddr[5:3];
  assign in_tready = (st_r == ST_IDLE) && !ovld_r;
  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    case (key_len_r)
      KL_128: begin nk_m1 = 3'd3; nr = 4'd10; nwords = 6'd44; end
      KL_192: begin nk_m1 = 3'd5; nr = 4'd12; nwords = 6'd52; end
      default: begin nk_m1 = 3'd7; nr = 4'd14; nwords = 6'd60; end
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= KL_128;
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
    end else if (cfg_wr) begin
      case (ra)
        REG_KL: key_len_r <= cfg_pwdata[1:0];
        REG_K0: key_r[0] <= cfg_pwdata;
        REG_K1: key_r[1] <= cfg_pwdata;
        REG_K2: key_r[2] <= cfg_pwdata;
        REG_K3: key_r[3] <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ra)
      REG_KL: cfg_prdata = {62'd0, key_len_r};
      REG_K0: cfg_prdata = key_r[0];
      REG_K1: cfg_prdata = key_r[1];
      REG_K2: cfg_prdata = key_r[2];
      REG_K3: cfg_prdata = key_r[3];
      default: cfg_prdata = '0;
    endcase
  end

  // key expansion word, one per cycle
  always_comb begin
    t = w1_r;
    if (kmod_r == 3'd0) begin
      t = sub_word({w1_r[23:0], w1_r[31:24]}) ^ {rcon_r, 24'd0};
    end else if (nk_m1 == 3'd7 && kmod_r == 3'd4) begin
      t = sub_word(w1_r);
    end
    if (widx_r <= {3'd0, nk_m1}) begin
      kw_new = widx_r[0] ? key_r[widx_r[2:1]][31:0] : key_r[widx_r[2:1]][63:32];
    end else begin
      kw_new = wnk[nk_m1] ^ t;
    end
  end

  // sequencer
  always_comb begin
    st_nxt = st_r;
    widx_nxt = widx_r;
    rnd_nxt = rnd_r;
    ctl = '0;
    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          st_nxt = (key_len_r == KL_INV) ? ST_OUT : ST_KEXP;
          widx_nxt = '0;
        end
      end
      ST_KEXP: begin
        widx_nxt = widx_r + 6'd1;
        if (widx_r == nwords - 6'd1) st_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        // rkey_r holds words 0..3 this cycle
        ctl.load = 1'b1;
        rnd_nxt = 4'd1;
        st_nxt = ST_RND;
      end
      ST_RND: begin
        ctl.step = 1'b1;
        ctl.last = (rnd_r == nr);
        rnd_nxt = rnd_r + 4'd1;
        if (rnd_r == nr) st_nxt = ST_OUT;
      end
      ST_OUT: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // round key store: one word lane written per cycle, the next round's entry registered ahead
  always_ff @(posedge clk) begin
    if (st_r == ST_KEXP) rk_mem[widx_r[5:2]][~widx_r[1:0]] <= kw_new;
  end

  always_ff @(posedge clk) begin
    rkey_r <= rk_mem[rnd_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      widx_r <= '0;
      rnd_r <= '0;
      ovld_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      widx_r <= widx_nxt;
      rnd_r <= (st_r == ST_KEXP) ? 4'd0 : rnd_nxt;
      if (st_r == ST_OUT) ovld_r <= 1'b1;
      else if (out_tready) ovld_r <= 1'b0;
    end
  end

  // key schedule counters and shift line
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kmod_r <= '0;
      rcon_r <= 8'h01;
    end else if (st_r == ST_KEXP) begin
      w1_r <= kw_new;
      wnk[0] <= kw_new;
      for (int i = 1; i < 8; i++) wnk[i] <= wnk[i-1];
      if (kmod_r == nk_m1) begin
        kmod_r <= '0;
        if (widx_r > {3'd0, nk_m1}) rcon_r <= xtime(rcon_r);
      end else begin
        kmod_r <= kmod_r + 3'd1;
      end
    end
    if (in_acc) blk_r <= in_tdata;
  end

  aes_round u_round (
    .clk   (clk),
    .ctl   (ctl),
    .blk   ({blk_r[63:0], blk_r[127:64]}),
    .rkey  (rkey_r),
    .state (rstate)
  );

  // result register
  always_ff @(posedge clk) begin
    if (st_r == ST_OUT) begin
      stat_r <= (key_len_r == KL_INV);
      res_r <= (key_len_r == KL_INV) ? '0 : rstate;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata = {7'd0, stat_r, res_r[63:0], res_r[127:64]};

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> !in_tready) else $error("accept while busy");
  a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovld_r) |-> $past(st_r) == ST_OUT) else $error("spurious result");
  a_rnd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RND) |-> rnd_r <= nr && rnd_r != 4'd0) else $error("round count");
`endif

endmodule

### hw/rtl/aes_round.sv
module aes_round import aes_pkg::*; (
  input  logic         clk,
  input  aes_rnd_ctl_t ctl,
  input  logic [127:0] blk,
  input  logic [127:0] rkey,
  output logic [127:0] state
);

  logic [127:0] state_r, state_nxt;
  logic [7:0]   sb [16];
  logic [7:0]   mx [16];
  logic [127:0] rnd;

  // byte k of state is bits [127-8k -: 8]; k = r + 4c
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[r + 4*c] = SBOX[state_r[127 - 8*(r + 4*((c + r) % 4)) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] al;
      al = sb[4*c] ^ sb[4*c+1] ^ sb[4*c+2] ^ sb[4*c+3];
      for (int r = 0; r < 4; r++) begin
        mx[4*c+r] = sb[4*c+r] ^ al ^ xtime(sb[4*c+r] ^ sb[4*c+((r+1)%4)]);
      end
    end
    for (int k = 0; k < 16; k++) begin
      rnd[127 - 8*k -: 8] = ctl.last ? sb[k] : mx[k];
    end
  end

  // initial add-key on load, one round per step
  always_comb begin
    state_nxt = state_r;
    if (ctl.load) begin
      state_nxt = blk ^ rkey;
    end else if (ctl.step) begin
      state_nxt = rnd ^ rkey;
    end
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
  end

  assign state = state_r;

endmodule

### tb/sv/tb_aes_block_encrypt.sv
module tb_aes_block_encrypt;
  import aes_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KL_BAD = 2'd3;
  localparam int REG_KEY_LENGTH = 0;
  localparam int REG_KEY_0 = 1;
  localparam int STALL_LIMIT = 4000;
  localparam int RAND_PHASES = 16;
  localparam int BLOCKS_PER_PHASE = 106;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        st;
  } cipher_res_t;

  // queue of expected ciphertexts, checked in order
  class cipher_board;
    cipher_res_t pending[$];
    int errors;
    int checked;

    function void note(cipher_res_t r);
      pending.push_back(r);
    endfunction

    function void check(cipher_res_t got);
      cipher_res_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: hi=%h lo=%h st=%b", got.hi, got.lo, got.st);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.hi !== want.hi || got.lo !== want.lo || got.st !== want.st) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp hi=%h lo=%h st=%b got hi=%h lo=%h st=%b",
                   want.hi, want.lo, want.st, got.hi, got.lo, got.st);
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;    // block_high, block_low
  logic         out_tvalid;
  logic         out_tready;
  logic [135:0] out_tdata;   // cipher_high, cipher_low, status, zero fill
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [5:0]   cfg_paddr;
  logic [63:0]  cfg_pwdata;
  logic [63:0]  cfg_prdata;
  logic         cfg_pready;

  aes_block_encrypt u_dut (.*);

  cipher_board board = new();
  logic [1:0]  cur_kl;
  logic [63:0] cur_key [4];
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cnt;
  int hold_reqs;
  int hold_seen;
  int quiet_cycles;
  int blocks_sent;
  int bad_key_blocks;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] gf_dbl(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // aes encryption of one block under the current key settings
  function automatic cipher_res_t encrypt_block(logic [1:0] kl, logic [63:0] key [4],
                                                logic [63:0] hi, logic [63:0] lo);
    logic [31:0] w [60];
    logic [7:0]  s [16];
    logic [7:0]  t [16];
    logic [7:0]  rc;
    logic [31:0] tw;
    logic [7:0]  a0, a1, a2, a3, al;
    int nk, nr;
    cipher_res_t r;
    if (kl == KL_BAD) begin
      r.hi = '0;
      r.lo = '0;
      r.st = 1'b1;
      return r;
    end
    nk = 4 + 2 * kl;
    nr = nk + 6;
    // key schedule
    for (int i = 0; i < nk; i++)
      w[i] = i[0] ? key[i >> 1][31:0] : key[i >> 1][63:32];
    rc = 8'h01;
    for (int i = nk; i < 4 * (nr + 1); i++) begin
      tw = w[i - 1];
      if (i % nk == 0) begin
        tw = {tw[23:0], tw[31:24]};
        tw = {SBOX[tw[31:24]], SBOX[tw[23:16]], SBOX[tw[15:8]], SBOX[tw[7:0]]};
        tw[31:24] ^= rc;
        rc = gf_dbl(rc);
      end else if (nk > 6 && i % nk == 4) begin
        tw = {SBOX[tw[31:24]], SBOX[tw[23:16]], SBOX[tw[15:8]], SBOX[tw[7:0]]};
      end
      w[i] = w[i - nk] ^ tw;
    end
    for (int i = 0; i < 8; i++) begin
      s[i] = hi[63 - 8 * i -: 8];
      s[i + 8] = lo[63 - 8 * i -: 8];
    end
    for (int rnd = 0; rnd <= nr; rnd++) begin
      if (rnd > 0) begin
        // sub bytes and shift rows
        for (int c = 0; c < 4; c++)
          for (int rw = 0; rw < 4; rw++)
            t[rw + 4 * c] = SBOX[s[rw + 4 * ((c + rw) % 4)]];
        s = t;
        // mix columns except in the final round
        if (rnd < nr) begin
          for (int c = 0; c < 4; c++) begin
            a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
            al = a0 ^ a1 ^ a2 ^ a3;
            s[4 * c]     = a0 ^ al ^ gf_dbl(a0 ^ a1);
            s[4 * c + 1] = a1 ^ al ^ gf_dbl(a1 ^ a2);
            s[4 * c + 2] = a2 ^ al ^ gf_dbl(a2 ^ a3);
            s[4 * c + 3] = a3 ^ al ^ gf_dbl(a3 ^ a0);
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int rw = 0; rw < 4; rw++)
          s[rw + 4 * c] ^= w[rnd * 4 + c][31 - 8 * rw -: 8];
    end
    for (int i = 0; i < 8; i++) begin
      r.hi[63 - 8 * i -: 8] = s[i];
      r.lo[63 - 8 * i -: 8] = s[i + 8];
    end
    r.st = 1'b0;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // register write: setup then access
  task automatic reg_write(int idx, logic [63:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 6'(8 * idx);
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_KEY_LENGTH) cur_kl = val[1:0];
    else cur_key[idx - REG_KEY_0] = val;
  endtask

  task automatic load_key(logic [1:0] kl, logic [63:0] k0, logic [63:0] k1,
                          logic [63:0] k2, logic [63:0] k3);
    reg_write(REG_KEY_LENGTH, {62'd0, kl});
    reg_write(REG_KEY_0, k0);
    reg_write(REG_KEY_0 + 1, k1);
    reg_write(REG_KEY_0 + 2, k2);
    reg_write(REG_KEY_0 + 3, k3);
  endtask

  // offer one block, valid stays high after the beat
  task automatic send_block(logic [63:0] hi, logic [63:0] lo);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {lo, hi};
    @(posedge clk);
    while (!(in_tvalid && in_tready)) @(posedge clk);
    board.note(encrypt_block(cur_kl, cur_key, hi, lo));
    blocks_sent++;
    if (cur_kl == KL_BAD) bad_key_blocks++;
  endtask

  // drop valid and wait for all ciphertexts plus core latency
  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // result side: check beats and apply backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_cnt <= 0;
      hold_seen <= 0;
    end else begin
      if (out_tvalid && out_tready)
        board.check({out_tdata[63:0], out_tdata[127:64], out_tdata[128]});
      if (hold_seen != hold_reqs) begin
        hold_seen <= hold_reqs;
        hold_cnt <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel || hold_cnt > 0)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [1:0] kl;
    logic [63:0] pat;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    hold_reqs = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    blocks_sent = 0;
    bad_key_blocks = 0;
    cur_kl = KL_128;
    for (int i = 0; i < 4; i++) cur_key[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: each key size and the bad code, extreme keys and blocks
    for (int d = 0; d < 4; d++) begin
      kl = 2'(d);
      load_key(kl, '0, '0, '1, '1);
      send_block('0, '0);
      send_block('1, '1);
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
      drain();
      load_key(kl, '1, '1, '0, '0);
      send_block(64'h8000000000000000, 64'h0000000000000001);
      send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
      drain();
    end

    // random phases over idling modes and key settings
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      kl = (p % 5 == 4) ? KL_BAD : 2'(p % 3);
      pat = (p == 1) ? '1 : '0;
      if (p < 2) load_key(kl, pat, pat, pat, pat);
      else load_key(kl, rand64(), rand64(), rand64(), rand64());
      // long receiver hold-off while blocks keep coming
      if (p == 5) hold_reqs++;
      for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
        case ($urandom_range(9))
          0: pat = '0;
          1: pat = '1;
          default: pat = rand64();
        endcase
        send_block(pat, rand64());
      end
      drain();
    end

    $display("covered %0d blocks (%0d under the invalid key code), %0d results checked",
             blocks_sent, bad_key_blocks, board.checked);
    $display("key sizes 128/192/256, zero and all-ones keys, four idling modes");
    if (board.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
hw/rtl/aes_pkg.sv
hw/rtl/aes_round.sv
hw/rtl/aes_block_encrypt.sv
tb/sv/tb_aes_block_encrypt.sv
